@@ rtl/core/bht_pkg.sv @@
// Shared types and constants of the bucketed hash table.
// Holds the item and result structs, operation and status codes, and the state codes.
// No dependencies.
`default_nettype none

package bht_pkg;

    localparam int HASH_W           = 32;
    localparam int VALUE_W          = 32;
    localparam int ENTRY_W          = 10;
    localparam int CFG_W            = 7;
    localparam int CFG_RESET        = 64;
    localparam int DEF_MAX_BUCKETS  = 64;
    localparam int DEF_SLOTS        = 8;
    localparam int MOD_BITS         = 8;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_LOOKUP = 2'd1,
        K_ERASE  = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FOUND   = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_MOD,
        S_FILL,
        S_SCAN,
        S_RESOLVE,
        S_SHIFT
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [HASH_W-1:0]  key_hash;
        logic [VALUE_W-1:0] value_in;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] value_out;
        logic [ENTRY_W-1:0] entry_count;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem;
    } t_mod_rsp;

endpackage

`default_nettype wire

@@ rtl/core/bht_mod_unit.sv @@
// Iterative remainder unit that reduces a key hash by the bucket count.
// Takes several bits of the dividend per cycle. Depends on bht_pkg.
`default_nettype none

module bht_mod_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bht_pkg::t_mod_req          i_req,
    input  wire logic [bht_pkg::CFG_W-1:0]  i_divisor,
    output bht_pkg::t_mod_rsp               o_rsp
);
    import bht_pkg::*;

    localparam int STEPS = HASH_W / MOD_BITS;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [HASH_W-1:0] r_dvd;
    logic [CFG_W-1:0]  r_rem;
    logic [CFG_W-1:0]  n_rem;

    always_comb begin
        logic [CFG_W:0] t;
        n_rem = r_rem;
        for (int i = 0; i < MOD_BITS; i++) begin
            t = {n_rem, r_dvd[HASH_W-1-i]};
            if (t >= {1'b0, i_divisor}) begin
                t = t - {1'b0, i_divisor};
            end
            n_rem = t[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << MOD_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

@@ rtl/core/bht_ctrl.sv @@
// Operation sequencer with the slot memory and the bucket fill memory.
// Scans a bucket slot by slot, appends, and compacts on erase. Depends on bht_pkg.
`default_nettype none

module bht_ctrl #(
    parameter int MAX_BUCKETS = bht_pkg::DEF_MAX_BUCKETS,
    parameter int SLOTS       = bht_pkg::DEF_SLOTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire bht_pkg::t_item     i_item,
    output logic                    o_busy,
    output logic                    o_valid,
    output bht_pkg::t_result        o_result,
    output bht_pkg::t_mod_req       o_mod_req,
    input  wire bht_pkg::t_mod_rsp  i_mod_rsp
);
    import bht_pkg::*;

    localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int FW    = $clog2(SLOTS + 1);
    localparam int IW    = FW + 1;
    localparam int TOTAL = MAX_BUCKETS * SLOTS;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int TW    = $clog2(TOTAL + 1);
    localparam int DW    = HASH_W + VALUE_W;

    logic [DW-1:0] r_slot_mem [TOTAL];
    logic [FW-1:0] r_fill_mem [MAX_BUCKETS];

    t_state             r_state, n_state;
    t_item              r_item, n_item;
    logic [BW-1:0]      r_bucket, n_bucket;
    logic [BW-1:0]      r_sweep, n_sweep;
    logic [FW-1:0]      r_fill, n_fill;
    logic [FW-1:0]      r_idx, n_idx;
    logic               r_found, n_found;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [TW-1:0]      r_total, n_total;
    logic               r_valid, n_valid;
    t_result            r_result, n_result;
    logic [DW-1:0]      r_slot_q;
    logic [FW-1:0]      r_fill_q;

    logic               slot_we;
    logic [AW-1:0]      slot_waddr, slot_raddr;
    logic [DW-1:0]      slot_wdata;
    logic               fill_we;
    logic [BW-1:0]      fill_waddr, fill_raddr;
    logic [FW-1:0]      fill_wdata;
    logic [AW-1:0]      base;
    logic [IW-1:0]      idx_next, idx_next2, fill_ext;

    assign base      = AW'(r_bucket) * AW'(SLOTS);
    assign idx_next  = {1'b0, r_idx} + IW'(1);
    assign idx_next2 = {1'b0, r_idx} + IW'(2);
    assign fill_ext  = {1'b0, r_fill};

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_q <= r_slot_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            r_fill_mem[fill_waddr] <= fill_wdata;
        end
        r_fill_q <= r_fill_mem[fill_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_sweep <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_total <= n_total;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_bucket <= n_bucket;
        r_fill   <= n_fill;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_value  <= n_value;
        r_result <= n_result;
    end

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_bucket   = r_bucket;
        n_sweep    = r_sweep;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_found    = r_found;
        n_value    = r_value;
        n_total    = r_total;
        n_valid    = 1'b0;
        n_result   = r_result;
        slot_we    = 1'b0;
        slot_waddr = base + AW'(r_idx);
        slot_wdata = r_slot_q;
        slot_raddr = base;
        fill_we    = 1'b0;
        fill_waddr = r_bucket;
        fill_wdata = '0;
        fill_raddr = r_bucket;
        o_mod_req.start    = 1'b0;
        o_mod_req.dividend = i_item.key_hash;

        unique case (r_state)
            S_INIT, S_CLEAR: begin
                fill_we    = 1'b1;
                fill_waddr = r_sweep;
                n_sweep    = r_sweep + 1'b1;
                if (r_sweep == BW'(MAX_BUCKETS - 1)) begin
                    n_state = S_IDLE;
                    n_total = '0;
                    n_sweep = '0;
                    if (r_state == S_CLEAR) begin
                        n_valid              = 1'b1;
                        n_result.status      = ST_DONE;
                        n_result.value_out   = '0;
                        n_result.entry_count = '0;
                    end
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_item = i_item;
                    if (i_item.kind == K_CLEAR) begin
                        n_state = S_CLEAR;
                        n_sweep = '0;
                    end else begin
                        o_mod_req.start = 1'b1;
                        n_state         = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (i_mod_rsp.done) begin
                    n_bucket   = BW'(i_mod_rsp.rem);
                    fill_raddr = BW'(i_mod_rsp.rem);
                    n_state    = S_FILL;
                end
            end
            S_FILL: begin
                n_fill  = r_fill_q;
                n_idx   = '0;
                n_found = 1'b0;
                n_value = '0;
                if (r_fill_q == '0) begin
                    n_state = S_RESOLVE;
                end else begin
                    slot_raddr = base;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_slot_q[DW-1 -: HASH_W] == r_item.key_hash) begin
                    n_found = 1'b1;
                    n_value = r_slot_q[VALUE_W-1:0];
                    n_state = S_RESOLVE;
                end else if (idx_next < fill_ext) begin
                    n_idx      = FW'(idx_next);
                    slot_raddr = base + AW'(idx_next);
                end else begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                n_state              = S_IDLE;
                n_valid              = 1'b1;
                n_result.value_out   = '0;
                n_result.entry_count = ENTRY_W'(r_total);
                unique case (r_item.kind)
                    K_INSERT: begin
                        if (r_found) begin
                            n_result.status    = ST_FOUND;
                            n_result.value_out = r_value;
                        end else if (fill_ext >= IW'(SLOTS)) begin
                            n_result.status = ST_FULL;
                        end else begin
                            slot_we    = 1'b1;
                            slot_waddr = base + AW'(r_fill);
                            slot_wdata = {r_item.key_hash, r_item.value_in};
                            fill_we    = 1'b1;
                            fill_wdata = r_fill + 1'b1;
                            n_total    = r_total + 1'b1;
                            n_result.status      = ST_DONE;
                            n_result.entry_count = ENTRY_W'(r_total + 1'b1);
                        end
                    end
                    K_LOOKUP: begin
                        if (r_found) begin
                            n_result.status    = ST_FOUND;
                            n_result.value_out = r_value;
                        end else begin
                            n_result.status = ST_MISSING;
                        end
                    end
                    K_ERASE: begin
                        if (!r_found) begin
                            n_result.status = ST_MISSING;
                        end else if (idx_next < fill_ext) begin
                            slot_raddr = base + AW'(idx_next);
                            n_valid    = 1'b0;
                            n_state    = S_SHIFT;
                        end else begin
                            fill_we    = 1'b1;
                            fill_wdata = r_fill - 1'b1;
                            n_total    = r_total - 1'b1;
                            n_result.status      = ST_FOUND;
                            n_result.value_out   = r_value;
                            n_result.entry_count = ENTRY_W'(r_total - 1'b1);
                        end
                    end
                    default: begin
                        n_result.status = ST_DONE;
                    end
                endcase
            end
            S_SHIFT: begin
                slot_we    = 1'b1;
                slot_waddr = base + AW'(r_idx);
                slot_wdata = r_slot_q;
                if (idx_next2 < fill_ext) begin
                    slot_raddr = base + AW'(idx_next2);
                    n_idx      = FW'(idx_next);
                end else begin
                    n_state    = S_IDLE;
                    fill_we    = 1'b1;
                    fill_wdata = r_fill - 1'b1;
                    n_total    = r_total - 1'b1;
                    n_valid    = 1'b1;
                    n_result.status      = ST_FOUND;
                    n_result.value_out   = r_value;
                    n_result.entry_count = ENTRY_W'(r_total - 1'b1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ rtl/core/bucketed_hash_table.sv @@
// Top level of the bucketed hash table: bucket count register and unit wiring.
// Depends on bht_pkg, bht_mod_unit and bht_ctrl.
//
// An item is taken when start is high and busy is low; its single result appears
// on o_result for exactly one cycle with o_valid high, and the receiver must take
// it then, since the block cannot hold it. For insert, lookup and erase, the
// remainder unit reduces eight hash bits per cycle and hands the remainder over,
// the fill of that bucket is read from the fill memory, and the scan reads one
// slot per cycle from the slot memory. An erase then moves each later slot of the
// bucket down by one. Clear writes the fill memory one bucket per cycle; the same
// pass runs after reset, with busy high. A new item may be started in the cycle
// its predecessor's result is shown. The user must write the bucket count only
// while busy is low; the block itself does not enforce it.
`default_nettype none

module bucketed_hash_table #(
    parameter int MAX_BUCKETS      = bht_pkg::DEF_MAX_BUCKETS,
    parameter int SLOTS_PER_BUCKET = bht_pkg::DEF_SLOTS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    input  wire bht_pkg::t_item             i_item,
    output logic                            busy,
    output logic                            o_valid,
    output bht_pkg::t_result                o_result,
    input  wire logic                       i_cfg_we,
    input  wire logic [bht_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import bht_pkg::*;

    function automatic logic [CFG_W-1:0] eff_divisor(input logic [CFG_W-1:0] bc);
        logic [CFG_W-1:0] d;
        d = bc;
        if (bc == '0) begin
            d = CFG_W'(1);
        end else if (int'(bc) > MAX_BUCKETS) begin
            d = CFG_W'(MAX_BUCKETS);
        end
        return d;
    endfunction

    logic [CFG_W-1:0] r_divisor;
    logic [CFG_W-1:0] n_divisor;
    t_mod_req         mod_req;
    t_mod_rsp         mod_rsp;

    assign n_divisor = eff_divisor(i_cfg_wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= eff_divisor(CFG_W'(CFG_RESET));
        end else if (i_cfg_we) begin
            r_divisor <= n_divisor;
        end
    end

    bht_mod_unit u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mod_req),
        .i_divisor (r_divisor),
        .o_rsp     (mod_rsp)
    );

    bht_ctrl #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .SLOTS       (SLOTS_PER_BUCKET)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .o_busy    (busy),
        .o_valid   (o_valid),
        .o_result  (o_result),
        .o_mod_req (mod_req),
        .i_mod_rsp (mod_rsp)
    );

endmodule

`default_nettype wire
